// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Whenever ante holds, cons holds in the same cycle.
`define SLAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Whenever ante holds, cons holds in the following cycle.
`define SLAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// The expression never holds.
`define SLAS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define SLAS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SLAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SLAS_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/core/slas_pkg.sv -----
package slas_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int LEVEL_W     = 7;
   localparam int COUNT_W     = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLEEP_ENABLE      = 3'd0,
      CSR_TIMER_WAKE_ENABLE = 3'd1,
      CSR_WAKE_MINUTES      = 3'd2,
      CSR_WOKE_BY_TIMER     = 3'd3,
      CSR_MANUAL_TIMEOUT    = 3'd4,
      CSR_TIMER_TIMEOUT     = 3'd5,
      CSR_LOW_BATTERY       = 3'd6,
      CSR_CRITICAL_BATTERY  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      COLOR_DARK  = 2'd0,
      COLOR_RED   = 2'd1,
      COLOR_GREEN = 2'd2,
      COLOR_WHITE = 2'd3
   } lamp_color_type;

   typedef enum logic {
      CMD_TICK     = 1'b0,
      CMD_ACTIVITY = 1'b1
   } command_type;

   localparam logic CAUSE_INACTIVITY = 1'b0;
   localparam logic CAUSE_BATTERY    = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic               command;
      logic               link_connected;
      logic [LEVEL_W-1:0] battery_reading;
   } req_word_type;

   typedef struct packed {
      logic               led_update;
      logic [1:0]         lamp_color;
      logic [LEVEL_W-1:0] battery_level;
      logic               sleep_request;
      logic               sleep_cause;
      logic               timer_wake;
   } rsp_word_type;

   typedef struct packed {
      logic               sleep_enable;
      logic               timer_wake_enable;
      logic [10:0]        wake_minutes;
      logic               woke_by_timer;
      logic [COUNT_W-1:0] manual_timeout_checks;
      logic [COUNT_W-1:0] timer_timeout_checks;
      logic [LEVEL_W-1:0] low_battery_pct;
      logic [LEVEL_W-1:0] critical_battery_pct;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sleep_enable:          1'b1,
      timer_wake_enable:     1'b0,
      wake_minutes:          11'd0,
      woke_by_timer:         1'b0,
      manual_timeout_checks: 16'd300,
      timer_timeout_checks:  16'd100,
      low_battery_pct:       7'd10,
      critical_battery_pct:  7'd5
   };

endpackage

// ----- rtl/core/slas_csr.sv -----
module slas_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slas_pkg::CSR_DATA_W-1:0]   csr_data,
   output slas_pkg::cfg_type                 cfg
);

   slas_pkg::cfg_type cfg_ff;
   slas_pkg::cfg_type cfg_in;
   slas_pkg::csr_index_type index;

   assign csr_ready = 1'b1;
   assign index     = slas_pkg::csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (index)
            slas_pkg::CSR_SLEEP_ENABLE:      cfg_in.sleep_enable = csr_data[0];
            slas_pkg::CSR_TIMER_WAKE_ENABLE: cfg_in.timer_wake_enable = csr_data[0];
            slas_pkg::CSR_WAKE_MINUTES:      cfg_in.wake_minutes = csr_data[10:0];
            slas_pkg::CSR_WOKE_BY_TIMER:     cfg_in.woke_by_timer = csr_data[0];
            slas_pkg::CSR_MANUAL_TIMEOUT:    cfg_in.manual_timeout_checks = csr_data;
            slas_pkg::CSR_TIMER_TIMEOUT:     cfg_in.timer_timeout_checks = csr_data;
            slas_pkg::CSR_LOW_BATTERY:
               cfg_in.low_battery_pct = csr_data[slas_pkg::LEVEL_W-1:0];
            slas_pkg::CSR_CRITICAL_BATTERY:
               cfg_in.critical_battery_pct = csr_data[slas_pkg::LEVEL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= slas_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/slas_core.sv -----
`include "assert_macros.svh"

module slas_core #(
   parameter int LED_DIVIDE     = 5,
   parameter int BATTERY_DIVIDE = 300,
   parameter int SLEEP_DIVIDE   = 2,
   parameter int BLINK_ON       = 1,
   parameter int BLINK_OFF      = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  slas_pkg::req_word_type req,
   input  slas_pkg::cfg_type      cfg,
   output slas_pkg::rsp_word_type rsp
);

   localparam int LedW     = (LED_DIVIDE > 1) ? $clog2(LED_DIVIDE) : 1;
   localparam int BatW     = (BATTERY_DIVIDE > 1) ? $clog2(BATTERY_DIVIDE) : 1;
   localparam int SlpW     = (SLEEP_DIVIDE > 1) ? $clog2(SLEEP_DIVIDE) : 1;
   localparam int Cycle    = BLINK_ON + BLINK_OFF;
   localparam int PhaseW   = (Cycle > 1) ? $clog2(Cycle) : 1;
   localparam logic [LedW-1:0]   LedLast   = LedW'(LED_DIVIDE - 1);
   localparam logic [BatW-1:0]   BatLast   = BatW'(BATTERY_DIVIDE - 1);
   localparam logic [SlpW-1:0]   SlpLast   = SlpW'(SLEEP_DIVIDE - 1);
   localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(Cycle - 1);
   localparam logic [PhaseW:0]   OnLimit   = (PhaseW + 1)'(BLINK_ON);

   logic [LedW-1:0]                 led_cnt_ff, led_cnt_in;
   logic [BatW-1:0]                 bat_cnt_ff, bat_cnt_in;
   logic [SlpW-1:0]                 slp_cnt_ff, slp_cnt_in;
   logic [PhaseW-1:0]               phase_ff, phase_in;
   logic [slas_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic [slas_pkg::COUNT_W-1:0]    idle_ff, idle_in;
   logic                            halted_ff, halted_in;

   logic                            tick;
   logic                            led_ev, bat_ev, slp_ev;
   logic [PhaseW-1:0]               phase_next;
   logic [1:0]                      color;
   logic [slas_pkg::LEVEL_W-1:0]    reading_sat;
   logic                            critical;
   logic [slas_pkg::COUNT_W-1:0]    idle_inc, limit;

   assign tick   = step && !halted_ff && (req.command == slas_pkg::CMD_TICK);
   assign led_ev = (led_cnt_ff == LedLast);
   assign bat_ev = (bat_cnt_ff == BatLast);
   assign slp_ev = (slp_cnt_ff == SlpLast);

   assign phase_next  = (phase_ff == PhaseLast) ? '0 : phase_ff + PhaseW'(1);
   assign reading_sat = (req.battery_reading > slas_pkg::LEVEL_FULL) ?
                        slas_pkg::LEVEL_FULL : req.battery_reading;
   assign critical    = bat_ev && (reading_sat < cfg.critical_battery_pct);
   assign idle_inc    = (idle_ff == slas_pkg::COUNT_MAX) ? idle_ff : idle_ff + 16'd1;
   assign limit       = cfg.woke_by_timer ? cfg.timer_timeout_checks
                                          : cfg.manual_timeout_checks;

   always_comb begin
      priority if (level_ff < cfg.low_battery_pct) begin
         color = slas_pkg::COLOR_RED;
      end else if (req.link_connected) begin
         color = slas_pkg::COLOR_GREEN;
      end else begin
         color = slas_pkg::COLOR_WHITE;
      end
   end

   always_comb begin
      led_cnt_in = led_cnt_ff;
      bat_cnt_in = bat_cnt_ff;
      slp_cnt_in = slp_cnt_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      idle_in    = idle_ff;
      halted_in  = halted_ff;
      rsp        = '0;

      if (step && !halted_ff && (req.command == slas_pkg::CMD_ACTIVITY)) begin
         idle_in = '0;
      end

      if (tick) begin
         led_cnt_in = led_ev ? '0 : led_cnt_ff + LedW'(1);
         bat_cnt_in = bat_ev ? '0 : bat_cnt_ff + BatW'(1);
         slp_cnt_in = slp_ev ? '0 : slp_cnt_ff + SlpW'(1);

         if (led_ev) begin
            phase_in       = phase_next;
            rsp.led_update = 1'b1;
            rsp.lamp_color = ({1'b0, phase_next} < OnLimit) ? color : slas_pkg::COLOR_DARK;
         end

         if (bat_ev) begin
            level_in = reading_sat;
         end

         if (critical) begin
            rsp.sleep_request = 1'b1;
            rsp.sleep_cause   = slas_pkg::CAUSE_BATTERY;
            halted_in         = 1'b1;
         end else if (slp_ev) begin
            // The check is skipped on a tick whose battery event already asked for sleep.
            if (!cfg.sleep_enable || req.link_connected) begin
               idle_in = '0;
            end else begin
               idle_in = idle_inc;
               if (idle_inc >= limit) begin
                  rsp.sleep_request = 1'b1;
                  rsp.sleep_cause   = slas_pkg::CAUSE_INACTIVITY;
                  rsp.timer_wake    = cfg.timer_wake_enable && (cfg.wake_minutes != '0);
                  halted_in         = 1'b1;
               end
            end
         end
      end

      rsp.battery_level = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_cnt_ff <= '0;
         bat_cnt_ff <= '0;
         slp_cnt_ff <= '0;
         phase_ff   <= '0;
         level_ff   <= slas_pkg::LEVEL_FULL;
         idle_ff    <= '0;
         halted_ff  <= 1'b0;
      end else begin
         led_cnt_ff <= led_cnt_in;
         bat_cnt_ff <= bat_cnt_in;
         slp_cnt_ff <= slp_cnt_in;
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         idle_ff    <= idle_in;
         halted_ff  <= halted_in;
      end
   end

   `SLAS_ASSERT_NEXT(a_halt_sticks, clock, reset, halted_ff, halted_ff)
   `SLAS_ASSERT_NEXT(a_request_halts, clock, reset, step && rsp.sleep_request, halted_ff)
   `SLAS_ASSERT_IMPL(a_battery_no_wake, clock, reset, rsp.sleep_cause, !rsp.timer_wake && rsp.sleep_request)
   `SLAS_ASSERT_NEXT(a_activity_clears, clock, reset, step && !halted_ff && req.command == slas_pkg::CMD_ACTIVITY, idle_ff == '0)

endmodule

// ----- rtl/core/status_led_and_auto_sleep_supervisor.sv -----
// Channel   Direction  Handshake        Word
// req       in         valid / stall    req_word_type (command, link, battery reading)
// rsp       out        valid / stall    rsp_word_type (LED, battery level, sleep request)
// csr       in         valid / ready    register index and data, always ready
//
// One word is accepted per cycle while req is not stalled; it passes through the input register,
// the step logic and the result register before its result is on rsp.
// Reset is synchronous: counters, blink phase and halt flag clear, battery level reads 100.
// A stall on rsp holds the result register; req stalls only while both registers are
// full and rsp is stalled.
`include "assert_macros.svh"

module status_led_and_auto_sleep_supervisor #(
   parameter int LED_DIVIDE     = 5,
   parameter int BATTERY_DIVIDE = 300,
   parameter int SLEEP_DIVIDE   = 2,
   parameter int BLINK_ON       = 1,
   parameter int BLINK_OFF      = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  slas_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output slas_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slas_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                   in_valid_ff, in_valid_in;
   slas_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff, out_valid_in;
   slas_pkg::rsp_word_type out_word_ff;
   slas_pkg::rsp_word_type step_rsp;
   slas_pkg::cfg_type      cfg;
   logic                   out_free;
   logic                   step;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign step     = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !out_free);

   slas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   slas_core #(
      .LED_DIVIDE     (LED_DIVIDE),
      .BATTERY_DIVIDE (BATTERY_DIVIDE),
      .SLEEP_DIVIDE   (SLEEP_DIVIDE),
      .BLINK_ON       (BLINK_ON),
      .BLINK_OFF      (BLINK_OFF)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_word_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         out_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `SLAS_ASSERT_IMPL(a_free_no_stall, clock, reset, !rsp_stall, !req_stall)
   `SLAS_ASSERT_NEXT(a_step_fills_out, clock, reset, step, rsp_valid)
   `SLAS_ASSERT_IMPL(a_stall_means_full, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule
